>>> rtl/slab_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// Slab slot allocator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SLAB_SLOT_ALLOCATOR_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SSA_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define SSA_ASSERT_NXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

>>> rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// Slab slot allocator package
// Transfer types, request and status codes, sequencer states, class tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;

    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_MEMORY = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_NULL_FREE = 3'd4;
    localparam logic [2:0] ST_NOT_SLAB  = 3'd5;
    localparam logic [2:0] ST_DUP_FREE  = 3'd6;
    localparam logic [2:0] ST_RELEASED  = 3'd7;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;

    localparam int MAP_BITS = 128;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] request_size;
        logic [31:0] free_address;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] slot_address;
        logic [1:0]  size_class;
        logic [5:0]  pages_returned;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_A, S_SCAN_I, S_SCAN_F, S_MAP_RD,
        S_FIND, S_FR_CHK, S_FR_MAP, S_REL, S_FIN
    } t_state;

    function automatic logic [6:0] slot_count(input logic [1:0] c);
        logic [6:0] n;
        case (c)
            2'd0:    n = 7'd126;
            2'd1:    n = 7'd63;
            2'd2:    n = 7'd31;
            default: n = 7'd15;
        endcase
        return n;
    endfunction

    // fresh page map with slot 0 already claimed
    function automatic logic [MAP_BITS-1:0] init_map(input logic [1:0] c);
        logic [MAP_BITS-1:0] m;
        m = (MAP_BITS'(1) << slot_count(c)) - MAP_BITS'(1);
        return m & ~MAP_BITS'(1);
    endfunction

    function automatic logic [2:0] pri8(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (v[k]) r = 3'(k);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ssa_map_ram.sv
// ----------------------------------------------------------------------------
// Slab slot allocator bitmap memory
// One free-slot map per page; one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_map_ram
    import ssa_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [MAP_BITS-1:0] i_wdata,
    input  wire logic [AW-1:0]       i_raddr,
    output logic      [MAP_BITS-1:0] o_rdata
);

    logic [MAP_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/slab_slot_allocator.sv
// Allocate: one too large goes straight to the result, else the page scans (one page a
// cycle) and the slot search (eight map bits a cycle) run. Free checks the page and
// slot bitmap, then may run the downward idle page return scan; release sweeps all
// pages downward. One request at a time: the next is taken in the cycle after the
// result registers, later while the previous result is held.
// Reset: every page free, idle counts zero, base page 0, idle limit 25; no clearing.
// ----------------------------------------------------------------------------
// Slab slot allocator top level
// Sequencer over a page scan, a bitmap slot search and the page return loop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slab_slot_allocator_macros.svh"

module slab_slot_allocator
    import ssa_pkg::*;
#(
    parameter int NUM_PAGES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam logic [PW-1:0] LAST = PW'(NUM_PAGES - 1);

    t_state r_state, n_state;
    logic [19:0] r_base;
    logic [5:0]  r_limit;
    logic [NUM_PAGES-1:0] r_owned;
    logic [1:0]  r_cls  [NUM_PAGES];
    logic        r_mode [NUM_PAGES];
    logic [6:0]  r_used [NUM_PAGES];
    logic [6:0]  r_idle [4];
    t_in         r_req;
    logic [1:0]  r_c;
    logic [PW-1:0] r_pg;
    logic [MAP_BITS-1:0] r_map;
    logic [6:0]  r_idx;
    logic [6:0]  r_ret;
    logic        r_flush;
    t_out        r_res;
    t_out        r_out;
    logic        r_out_valid;

    logic        w_acc;
    logic [1:0]  w_class_req;
    logic        w_too_large, w_null, w_oob;
    logic [19:0] w_diff;
    logic        w_own, w_mode;
    logic [1:0]  w_cls;
    logic [6:0]  w_used, w_cnt;
    logic        w_hit_a, w_hit_i, w_hit_r, w_rel_go;
    logic [MAP_BITS-1:0] w_rd;
    logic        w_we;
    logic [MAP_BITS-1:0] w_wdata;
    logic [11:0] w_off;
    logic [6:0]  w_fi;
    logic [6:0]  w_fidx;
    logic        w_found;
    logic [6:0]  w_new_used;
    logic [31:0] w_slot0, w_slotf;
    logic        w_fin_go;

    ssa_map_ram #(.DEPTH(NUM_PAGES), .AW(PW)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pg),
        .i_wdata (w_wdata),
        .i_raddr (r_pg),
        .o_rdata (w_rd)
    );

    assign w_acc       = i_valid && !o_stall;
    assign w_too_large = i_data.request_size > 16'd256;
    assign w_class_req = (i_data.request_size > 16'd128) ? 2'd3 :
                         (i_data.request_size > 16'd64)  ? 2'd2 :
                         (i_data.request_size > 16'd32)  ? 2'd1 : 2'd0;
    assign w_null      = i_data.free_address == 32'd0;
    assign w_diff      = i_data.free_address[31:12] - r_base;
    assign w_oob       = (i_data.free_address[31:12] < r_base) ||
                         (w_diff >= 20'(NUM_PAGES));

    assign w_own   = r_owned[r_pg];
    assign w_mode  = r_mode[r_pg];
    assign w_cls   = r_cls[r_pg];
    assign w_used  = r_used[r_pg];
    assign w_cnt   = slot_count(r_c);
    assign w_hit_a = w_own && (w_cls == r_c) && w_mode && (w_used < w_cnt);
    assign w_hit_i = w_own && (w_cls == r_c) && !w_mode;
    assign w_hit_r = w_own && !w_mode && (r_flush || (w_cls == r_c));
    assign w_rel_go = r_flush || (r_idle[r_c] > {1'b0, r_limit});

    assign w_off  = r_req.free_address[11:0];
    assign w_fi   = 7'((w_off - 12'd64) >> (w_cls + 4'd5));
    assign w_found = |r_map[7:0];
    assign w_fidx = r_idx + {4'd0, pri8(r_map[7:0])};
    assign w_new_used = (w_used > 7'd0) ? w_used - 7'd1 : 7'd0;

    assign w_slot0 = {r_base + 20'(r_pg), 12'd0} + 32'd64;
    assign w_slotf = w_slot0 + (32'(w_fidx) << (r_c + 4'd5));
    assign w_fin_go = !r_out_valid || !i_stall;

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_rd;
        unique case (r_state)
            S_SCAN_I: begin
                w_we    = w_hit_i;
                w_wdata = init_map(r_c);
            end
            S_SCAN_F: begin
                w_we    = !w_own;
                w_wdata = init_map(r_c);
            end
            S_FIND: begin
                w_we    = w_found;
                w_wdata = w_rd & ~(MAP_BITS'(1) << w_fidx);
            end
            S_FR_MAP: begin
                w_we    = !w_rd[r_idx];
                w_wdata = w_rd | (MAP_BITS'(1) << r_idx);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_data.req_type == REQ_ALLOC) begin
                        n_state = w_too_large ? S_FIN : S_SCAN_A;
                    end else if (i_data.req_type == REQ_FREE) begin
                        n_state = (w_null || w_oob) ? S_FIN : S_FR_CHK;
                    end else begin
                        n_state = S_REL;
                    end
                end
            end
            S_SCAN_A: begin
                if (w_hit_a) n_state = S_MAP_RD;
                else if (r_pg == LAST) n_state = S_SCAN_I;
            end
            S_SCAN_I: begin
                if (w_hit_i) n_state = S_FIN;
                else if (r_pg == LAST) n_state = S_SCAN_F;
            end
            S_SCAN_F: begin
                if (!w_own || r_pg == LAST) n_state = S_FIN;
            end
            S_MAP_RD: n_state = S_FIND;
            S_FIND: begin
                if (w_found) n_state = S_FIN;
            end
            S_FR_CHK: begin
                if (!w_own || w_off < 12'd64 || w_fi >= slot_count(w_cls) || !w_mode) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_FR_MAP;
                end
            end
            S_FR_MAP: begin
                n_state = (!w_rd[r_idx] && w_new_used == 7'd0) ? S_REL : S_FIN;
            end
            S_REL: begin
                if (!w_rel_go || r_pg == '0) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_fin_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = r_state != S_IDLE;
        o_cfg_ready = 1'b1;
        o_valid     = r_out_valid;
        o_data      = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= 20'd0;
            r_limit     <= 6'd25;
            r_owned     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) r_idle[k] <= 7'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BASE) r_base <= i_cfg_data;
                else if (i_cfg_index == CFG_LIMIT) r_limit <= i_cfg_data[5:0];
            end
            if (r_out_valid && !i_stall && r_state != S_FIN) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_req   <= i_data;
                        r_ret   <= 7'd0;
                        r_flush <= 1'b0;
                        r_c     <= w_class_req;
                        if (i_data.req_type == REQ_ALLOC) begin
                            r_pg <= '0;
                            if (w_too_large) begin
                                r_res <= t_out'{status: ST_TOO_LARGE, default: '0};
                            end else begin
                                r_res <= t_out'{size_class: w_class_req, default: '0};
                            end
                        end else if (i_data.req_type == REQ_FREE) begin
                            r_pg  <= w_diff[PW-1:0];
                            r_res <= t_out'{status: w_null ? ST_NULL_FREE : ST_NOT_SLAB,
                                            default: '0};
                        end else begin
                            r_flush <= 1'b1;
                            r_pg    <= LAST;
                            r_res   <= t_out'{status: ST_RELEASED, default: '0};
                        end
                    end
                end
                S_SCAN_A: begin
                    if (!w_hit_a) r_pg <= (r_pg == LAST) ? '0 : r_pg + 1'b1;
                end
                S_SCAN_I: begin
                    if (w_hit_i) begin
                        r_mode[r_pg] <= 1'b1;
                        r_used[r_pg] <= 7'd1;
                        if (r_idle[r_c] > 7'd0) r_idle[r_c] <= r_idle[r_c] - 7'd1;
                        r_res.status       <= ST_ALLOCATED;
                        r_res.slot_address <= w_slot0;
                    end else begin
                        r_pg <= (r_pg == LAST) ? '0 : r_pg + 1'b1;
                    end
                end
                S_SCAN_F: begin
                    if (!w_own) begin
                        r_owned[r_pg] <= 1'b1;
                        r_cls[r_pg]   <= r_c;
                        r_mode[r_pg]  <= 1'b1;
                        r_used[r_pg]  <= 7'd1;
                        r_res.status       <= ST_ALLOCATED;
                        r_res.slot_address <= w_slot0;
                    end else if (r_pg == LAST) begin
                        r_res.status <= ST_NO_MEMORY;
                    end else begin
                        r_pg <= r_pg + 1'b1;
                    end
                end
                S_MAP_RD: begin
                    r_map <= w_rd;
                    r_idx <= 7'd0;
                end
                S_FIND: begin
                    if (w_found) begin
                        r_used[r_pg]       <= w_used + 7'd1;
                        r_res.status       <= ST_ALLOCATED;
                        r_res.slot_address <= w_slotf;
                    end else begin
                        r_map <= r_map >> 8;
                        r_idx <= r_idx + 7'd8;
                    end
                end
                S_FR_CHK: begin
                    r_c   <= w_cls;
                    r_idx <= w_fi;
                    if (w_own && w_off >= 12'd64 && w_fi < slot_count(w_cls)) begin
                        r_res.size_class <= w_cls;
                        r_res.status     <= ST_DUP_FREE;
                    end
                end
                S_FR_MAP: begin
                    if (!w_rd[r_idx]) begin
                        r_res.status <= ST_FREED;
                        r_used[r_pg] <= w_new_used;
                        if (w_new_used == 7'd0) begin
                            r_mode[r_pg] <= 1'b0;
                            r_idle[r_c]  <= r_idle[r_c] + 7'd1;
                            r_pg         <= LAST;
                        end
                    end
                end
                S_REL: begin
                    if (w_rel_go) begin
                        if (w_hit_r) begin
                            r_owned[r_pg] <= 1'b0;
                            if (r_idle[w_cls] > 7'd0) r_idle[w_cls] <= r_idle[w_cls] - 7'd1;
                            r_ret <= r_ret + 7'd1;
                        end
                        if (r_pg != '0) r_pg <= r_pg - 1'b1;
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_out       <= t_out'{status: r_res.status,
                                              slot_address: r_res.slot_address,
                                              size_class: r_res.size_class,
                                              pages_returned: r_ret[5:0]};
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `SSA_ASSERT_IMP(a_find_has_free, r_state == S_FIND, r_map != '0, "slot search on full map")
    `SSA_ASSERT_NXT(a_flush_stays, r_state == S_REL && r_flush, r_state == S_REL || r_state == S_FIN, "release sweep left early")
    `SSA_ASSERT_IMP(a_out_from_fin, $rose(r_out_valid), $past(r_state) == S_FIN, "result raised outside finish")

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Slab slot allocator testbench
// Directed table then random allocate/free/release traffic, with random idling
// on both channels; each result is checked field by field against a predictor
// of page ownership, slot bitmaps and idle page counts.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import ssa_pkg::*;

    localparam int NPAGES = 32;
    localparam int LIMIT_CYCLES = 2000000;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_UNDEF = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    slab_slot_allocator #(.NUM_PAGES(NPAGES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // allocator shadow state
    logic [19:0]  base_page;
    logic [5:0]   idle_limit;
    logic         owned [NPAGES];
    logic [1:0]   pclass [NPAGES];
    logic         active [NPAGES];
    logic [6:0]   used [NPAGES];
    logic [127:0] fmap [NPAGES];
    logic [5:0]   idle_cnt [4];

    t_out   pending_results[$];
    logic   typed_valid[$];
    t_out   typed_results[$];
    logic [31:0] live_slots[$];

    int  mismatches;
    int  cycles;
    bit  timed_out;
    bit  rx_hold;
    bit  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [6:0] nslots(input logic [1:0] c);
        case (c)
            2'd0: return 7'd126;
            2'd1: return 7'd63;
            2'd2: return 7'd31;
            default: return 7'd15;
        endcase
    endfunction

    function automatic logic [31:0] page_addr(input int p);
        return (32'(base_page) + 32'(p)) << 12;
    endfunction

    function automatic void take_page(input int p, input logic [1:0] c);
        owned[p] = 1'b1;
        pclass[p] = c;
        active[p] = 1'b1;
        used[p] = '0;
        fmap[p] = (128'd1 << nslots(c)) - 128'd1;
    endfunction

    function automatic bit drop_highest_idle(input logic [1:0] c);
        for (int p = NPAGES - 1; p >= 0; p--) begin
            if (owned[p] && pclass[p] == c && !active[p]) begin
                owned[p] = 1'b0;
                if (idle_cnt[c] > 0) idle_cnt[c]--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out allocator_result(input t_in req);
        t_out r;
        int sel;
        int i;
        logic [1:0] c;
        logic [31:0] addr, pn, off, idx;
        logic [5:0] ret;
        r = '0;
        sel = -1;
        ret = '0;
        if (req.req_type == REQ_ALLOC) begin
            if (req.request_size > 16'd256) begin
                r.status = ST_TOO_LARGE;
                return r;
            end
            c = (req.request_size > 128) ? 2'd3 : (req.request_size > 64) ? 2'd2 :
                (req.request_size > 32) ? 2'd1 : 2'd0;
            r.size_class = c;
            for (int p = 0; p < NPAGES && sel < 0; p++)
                if (owned[p] && pclass[p] == c && active[p] && used[p] < nslots(c))
                    sel = p;
            for (int p = 0; p < NPAGES && sel < 0; p++)
                if (owned[p] && pclass[p] == c && !active[p]) begin
                    sel = p;
                    if (idle_cnt[c] > 0) idle_cnt[c]--;
                    take_page(p, c);
                end
            for (int p = 0; p < NPAGES && sel < 0; p++)
                if (!owned[p]) begin
                    sel = p;
                    take_page(p, c);
                end
            if (sel < 0) begin
                r.status = ST_NO_MEMORY;
                return r;
            end
            for (i = 0; i < nslots(c); i++)
                if (fmap[sel][i]) break;
            fmap[sel][i] = 1'b0;
            used[sel]++;
            r.status = ST_ALLOCATED;
            r.slot_address = page_addr(sel) + 32'd64 + 32'(i) * (32'd32 << c);
        end else if (req.req_type == REQ_FREE) begin
            addr = req.free_address;
            if (addr == 0) begin
                r.status = ST_NULL_FREE;
                return r;
            end
            pn = addr >> 12;
            if (pn < 32'(base_page) || pn - 32'(base_page) >= NPAGES) begin
                r.status = ST_NOT_SLAB;
                return r;
            end
            sel = int'(pn - 32'(base_page));
            if (!owned[sel]) begin
                r.status = ST_NOT_SLAB;
                return r;
            end
            c = pclass[sel];
            off = addr & 32'hFFF;
            if (off < 64) begin
                r.status = ST_NOT_SLAB;
                return r;
            end
            idx = (off - 32'd64) >> (5 + c);
            if (idx >= 32'(nslots(c))) begin
                r.status = ST_NOT_SLAB;
                return r;
            end
            r.size_class = c;
            if (!active[sel] || fmap[sel][idx]) begin
                r.status = ST_DUP_FREE;
                return r;
            end
            fmap[sel][idx] = 1'b1;
            if (used[sel] > 0) used[sel]--;
            if (used[sel] == 0) begin
                active[sel] = 1'b0;
                idle_cnt[c]++;
                while (idle_cnt[c] > idle_limit && drop_highest_idle(c)) ret++;
            end
            r.status = ST_FREED;
            r.pages_returned = ret;
        end else begin
            for (int k = 0; k < 4; k++)
                while (drop_highest_idle(2'(k))) ret++;
            r.status = ST_RELEASED;
            r.pages_returned = ret;
        end
        return r;
    endfunction

    task automatic tick();
        @(posedge i_clk);
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            timed_out = 1'b1;
            $display("TEST FAILED");
            $finish;
        end
    endtask

    task automatic send_request(input t_in req, input bit has_typed, input t_out typed);
        while (!no_idle && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            tick();
        end
        i_valid <= 1'b1;
        i_data <= req;
        pending_results.push_back(allocator_result(req));
        typed_valid.push_back(has_typed);
        typed_results.push_back(typed);
        do tick(); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() > 0) tick();
        repeat (3 * NPAGES + 30) tick();
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do tick(); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tick();
        if (idx == CFG_BASE) base_page = val;
        else idle_limit = val[5:0];
    endtask

    function automatic t_in mk(input logic [1:0] t, input logic [15:0] s,
                               input logic [31:0] a);
        t_in q;
        q.req_type = t;
        q.request_size = s;
        q.free_address = a;
        return q;
    endfunction

    function automatic t_out res(input logic [2:0] st, input logic [31:0] a,
                                 input logic [1:0] c, input logic [5:0] n);
        t_out o;
        o.status = st;
        o.slot_address = a;
        o.size_class = c;
        o.pages_returned = n;
        return o;
    endfunction

    // receive side: random stalls, and a long hold-off when asked
    initial begin
        i_stall = 1'b1;
        @(posedge i_clk);
        forever begin
            if (rx_hold) i_stall <= 1'b1;
            else i_stall <= !no_idle && ($urandom_range(99) < 27);
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: %p", o_data);
                end else begin
                    t_out want;
                    bit   has_t;
                    t_out tv;
                    want = pending_results.pop_front();
                    has_t = typed_valid.pop_front();
                    tv = typed_results.pop_front();
                    if (has_t && tv !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row disagrees: typed %p predicted %p", tv, want);
                    end
                    if (o_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, o_data);
                    end else if (want.status == ST_ALLOCATED) begin
                        live_slots.push_back(want.slot_address);
                    end
                end
            end
        end
    end

    initial begin
        t_in  rows[$];
        t_out rows_exp[$];
        bit   rows_typed[$];
        t_in  q;
        int   k, pick, phase;
        logic [31:0] a;

        cycles = 0;
        mismatches = 0;
        timed_out = 1'b0;
        rx_hold = 1'b0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data = '0;
        base_page = '0;
        idle_limit = 6'd25;
        for (int p = 0; p < NPAGES; p++) begin
            owned[p] = 0; pclass[p] = 0; active[p] = 0; used[p] = 0; fmap[p] = 0;
        end
        for (int c = 0; c < 4; c++) idle_cnt[c] = 0;
        repeat (3) tick();
        i_rst_n <= 1'b1;
        tick();

        // directed table
        rows = '{mk(REQ_ALLOC, 16'd0, 0), mk(REQ_ALLOC, 16'd32, 0),
                 mk(REQ_ALLOC, 16'd33, 0), mk(REQ_ALLOC, 16'd65, 0),
                 mk(REQ_ALLOC, 16'd256, 0), mk(REQ_ALLOC, 16'd257, 0),
                 mk(REQ_ALLOC, 16'hFFFF, 0), mk(REQ_FREE, 0, 32'd0),
                 mk(REQ_FREE, 0, 32'hFFFF_FFFF), mk(REQ_FREE, 0, 32'd10),
                 mk(REQ_FREE, 0, 32'd4095), mk(REQ_FREE, 0, 32'd72),
                 mk(REQ_FREE, 0, 32'd64), mk(REQ_FREE, 0, 32'd64),
                 mk(REQ_FREE, 0, 32'h5040), mk(REQ_FREE, 0, 32'h1000 + 32'd100),
                 mk(REQ_FLUSH, 0, 0), mk(REQ_UNDEF, 16'hFFFF, 32'hFFFF_FFFF)};
        rows_typed = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 1, 0, 0, 1};
        rows_exp = '{res(ST_ALLOCATED, 32'h40, 0, 0), res(ST_ALLOCATED, 32'h60, 0, 0),
                     res(ST_ALLOCATED, 32'h1040, 1, 0), res(ST_ALLOCATED, 32'h2040, 2, 0),
                     res(ST_ALLOCATED, 32'h3040, 3, 0), res(ST_TOO_LARGE, 0, 0, 0),
                     res(ST_TOO_LARGE, 0, 0, 0), res(ST_NULL_FREE, 0, 0, 0),
                     res(ST_NOT_SLAB, 0, 0, 0), res(ST_NOT_SLAB, 0, 0, 0),
                     res(ST_DUP_FREE, 0, 0, 0), '0, '0, '0,
                     res(ST_NOT_SLAB, 0, 0, 0), '0, '0, res(ST_RELEASED, 0, 0, 0)};
        for (k = 0; k < rows.size(); k++) send_request(rows[k], rows_typed[k], rows_exp[k]);
        drain();
        live_slots.delete();

        // random phases over several register settings
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(CFG_LIMIT, 20'd0); write_reg(CFG_BASE, 20'hFFFFF); end
                1: begin write_reg(CFG_LIMIT, 20'd63); write_reg(CFG_BASE, 20'h12345); end
                2: begin write_reg(CFG_LIMIT, 20'd32); write_reg(CFG_BASE, 20'h0); end
                3: begin write_reg(CFG_LIMIT, 20'd1); write_reg(CFG_BASE, 20'hAAAAA); end
                4: begin write_reg(CFG_LIMIT, 20'($urandom_range(63)));
                         write_reg(CFG_BASE, 20'($urandom)); end
                default: begin write_reg(CFG_LIMIT, 20'd3); write_reg(CFG_BASE, 20'h55555); end
            endcase
            live_slots.delete();
            no_idle = (phase == 2);
            for (k = 0; k < 200; k++) begin
                pick = $urandom_range(99);
                if (phase == 1 && k == 50) begin
                    rx_hold = 1'b1;
                    fork
                        begin repeat (300) @(posedge i_clk); rx_hold = 1'b0; end
                    join_none
                end
                if (k == 120) begin
                    i_valid <= 1'b0;
                    tick();
                    while (pending_results.size() > 0) tick();
                end
                if (pick < 45) begin
                    q = mk(REQ_ALLOC, ($urandom_range(9) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(256)), 32'($urandom));
                end else if (pick < 85 && live_slots.size() > 0) begin
                    pick = $urandom_range(live_slots.size() - 1);
                    a = live_slots[pick];
                    live_slots.delete(pick);
                    if ($urandom_range(3) == 0) a = a + 32'($urandom_range(31));
                    q = mk(REQ_FREE, 16'($urandom), a);
                end else if (pick < 95) begin
                    case ($urandom_range(3))
                        0: a = 32'($urandom);
                        1: a = page_addr($urandom_range(NPAGES)) + 32'($urandom_range(4095));
                        2: a = 32'd0;
                        default: a = page_addr($urandom_range(NPAGES - 1)) + 32'd64;
                    endcase
                    q = mk(REQ_FREE, 16'($urandom), a);
                end else begin
                    q = mk(2'($urandom_range(2, 3)), 16'($urandom), 32'($urandom));
                end
                send_request(q, 1'b0, '0);
            end
            drain();
        end

        if (mismatches == 0 && !timed_out) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/ssa_pkg.sv
rtl/ssa_map_ram.sv
rtl/slab_slot_allocator.sv
test/testbench.sv
